// ===== rtl/core/vector_rotate_degrees_macros.svh =====
// Assertion helpers used by the checker of this block.
// Every property is clocked on clk and switched off while rst_n is low.
`ifndef VECTOR_ROTATE_DEGREES_MACROS_SVH
`define VECTOR_ROTATE_DEGREES_MACROS_SVH

// A condition that must hold at every rising clock edge.
`define VRD_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define VRD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold after the delay given by dly.
`define VRD_ASSERT_DELAY(name, ante, dly, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vrd_pkg.sv =====
package vrd_pkg;

    localparam int VEC_W       = 32;
    localparam int ANG_IN_W    = 16;
    // Offset angle: the input plus a multiple of 360, always non-negative.
    localparam int ANG_W       = 17;
    localparam int DEG_W       = 9;
    localparam int TAB_IDX_W   = 7;
    localparam int TRIG_FRAC   = 16;
    localparam int TRIG_W      = TRIG_FRAC + 2;
    localparam int PROD_W      = VEC_W + TRIG_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int RND_W       = SUM_W + 1 - TRIG_FRAC;
    localparam int MOD_CELLS   = 8;
    localparam int MATH_STAGES = 4;
    localparam int LATENCY     = MOD_CELLS + MATH_STAGES;
    localparam int DEG_FULL    = 360;

    // 92 * 360 lifts the most negative input angle above zero.
    localparam logic [ANG_W-1:0] ANG_OFFSET = ANG_W'(92 * DEG_FULL);

    localparam logic [DEG_W-1:0] DEG_90  = DEG_W'(90);
    localparam logic [DEG_W-1:0] DEG_180 = DEG_W'(180);
    localparam logic [DEG_W-1:0] DEG_270 = DEG_W'(270);
    localparam logic [DEG_W-1:0] DEG_360 = DEG_W'(DEG_FULL);

    localparam logic signed [VEC_W-1:0] SAT_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam logic signed [VEC_W-1:0] SAT_MIN = {1'b1, {(VEC_W-1){1'b0}}};

    localparam logic signed [SUM_W:0] ROUND_HALF = (SUM_W+1)'(64'd1 << (TRIG_FRAC - 1));

    typedef struct packed {
        logic signed [VEC_W-1:0]    vec_x;
        logic signed [VEC_W-1:0]    vec_y;
        logic signed [ANG_IN_W-1:0] angle_deg;
    } vrd_in_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] rot_x;
        logic signed [VEC_W-1:0] rot_y;
        logic                    saturated;
    } vrd_out_t;

    // One word moving down the modulo chain.
    typedef struct packed {
        logic                    valid;
        logic [ANG_W-1:0]        angle;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
    } vrd_word_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] value;
        logic                    clip;
    } vrd_sat_t;

    // round(sin(k degrees) * 2^16) for k = 0..90.
    localparam logic [TRIG_FRAC:0] SIN_TAB [0:90] = '{
        17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,
        17'd5712,  17'd6850,  17'd7987,  17'd9121,  17'd10252,
        17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
        17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336,
        17'd22415, 17'd23486, 17'd24550, 17'd25607, 17'd26656,
        17'd27697, 17'd28729, 17'd29753, 17'd30767, 17'd31772,
        17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
        17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243,
        17'd42126, 17'd42995, 17'd43852, 17'd44695, 17'd45525,
        17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
        17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020,
        17'd53684, 17'd54332, 17'd54963, 17'd55578, 17'd56175,
        17'd56756, 17'd57319, 17'd57865, 17'd58393, 17'd58903,
        17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
        17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997,
        17'd63303, 17'd63589, 17'd63856, 17'd64104, 17'd64332,
        17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
        17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526,
        17'd65536
    };

    // Signed sine of an angle in 0..359, folded onto the first quadrant.
    function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [DEG_W-1:0] a);
        logic [DEG_W-1:0]         k;
        logic                     neg;
        logic signed [TRIG_W-1:0] mag;
        if (a <= DEG_90)
        begin
            k   = a;
            neg = 1'b0;
        end
        else if (a <= DEG_180)
        begin
            k   = DEG_180 - a;
            neg = 1'b0;
        end
        else if (a <= DEG_270)
        begin
            k   = a - DEG_180;
            neg = 1'b1;
        end
        else
        begin
            k   = DEG_360 - a;
            neg = 1'b1;
        end
        mag = $signed({1'b0, SIN_TAB[k[TAB_IDX_W-1:0]]});
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [TRIG_W-1:0] cos_deg(input logic [DEG_W-1:0] a);
        logic [DEG_W-1:0] b;
        b = a + DEG_90;
        if (b >= DEG_360)
        begin
            b = b - DEG_360;
        end
        return sin_deg(b);
    endfunction

    // Round half up from Q(VEC+TRIG) to Q(VEC), then clip to the word range.
    function automatic vrd_sat_t round_sat(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W:0]    biased;
        logic        [RND_W-1:0]  rnd;
        logic [RND_W-VEC_W:0]     hi;
        vrd_sat_t                 res;
        biased    = $signed({sum[SUM_W-1], sum}) + ROUND_HALF;
        rnd       = biased[SUM_W:TRIG_FRAC];
        hi        = rnd[RND_W-1:VEC_W-1];
        res.clip  = !((&hi) || (~|hi));
        if (res.clip)
        begin
            res.value = rnd[RND_W-1] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            res.value = $signed(rnd[VEC_W-1:0]);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/vector_rotate_degrees.sv =====
// Rotates a signed Q16.16 vector counterclockwise by a whole-degree angle of any
// value, using a 1-degree sine table in Q1.16. The block takes one word per clock
// cycle and never stalls: busy stays low, and each result appears on rsp for a
// single cycle with done high. Each word passes first through a chain of eight
// registered compare-and-subtract cells that reduces the angle modulo 360, then
// through four registered stages: table lookup, multiply, sum, and round/clip.
// Results leave in the order words went in; outputs that clip set saturated.
module vector_rotate_degrees (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  vrd_pkg::vrd_in_t req,
    output logic             done,
    output vrd_pkg::vrd_out_t rsp
);

    localparam int NC = vrd_pkg::MOD_CELLS;

    vrd_pkg::vrd_word_t chain [0:NC];

    assign busy = 1'b0;

    always_comb
    begin
        chain[0].valid = start & ~busy;
        chain[0].angle = {req.angle_deg[vrd_pkg::ANG_IN_W-1], req.angle_deg}
                         + vrd_pkg::ANG_OFFSET;
        chain[0].vec_x = req.vec_x;
        chain[0].vec_y = req.vec_y;
    end

    // Cells subtract 360 * 128 first, down to 360 * 1 at the end.
    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        vrd_mod_cell #(
            .SHIFT(NC - 1 - i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .word_in (chain[i]),
            .word_out(chain[i+1])
        );
    end

    vrd_rotator u_rot (
        .clk    (clk),
        .rst_n  (rst_n),
        .word_in(chain[NC]),
        .done   (done),
        .rsp    (rsp)
    );

endmodule

// ===== rtl/core/vrd_mod_cell.sv =====
// One cell of the modulo-360 chain: subtracts 360 * 2^SHIFT when it fits.
module vrd_mod_cell #(
    parameter int SHIFT = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vrd_pkg::vrd_word_t word_in,
    output vrd_pkg::vrd_word_t word_out
);

    localparam int AW = vrd_pkg::ANG_W;
    localparam logic [AW-1:0] STEP = AW'(vrd_pkg::DEG_FULL << SHIFT);

    logic                            valid_reg;
    logic [AW-1:0]                   angle_reg;
    logic [AW-1:0]                   angle_next;
    logic signed [vrd_pkg::VEC_W-1:0] x_reg;
    logic signed [vrd_pkg::VEC_W-1:0] y_reg;

    always_comb
    begin
        angle_next = (word_in.angle >= STEP) ? (word_in.angle - STEP) : word_in.angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= word_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        x_reg     <= word_in.vec_x;
        y_reg     <= word_in.vec_y;
    end

    assign word_out.valid = valid_reg;
    assign word_out.angle = angle_reg;
    assign word_out.vec_x = x_reg;
    assign word_out.vec_y = y_reg;

endmodule

// ===== rtl/core/vrd_rotator.sv =====
// Table lookup, four products, the two sums, then rounding and clipping.
module vrd_rotator (
    input  logic               clk,
    input  logic               rst_n,
    input  vrd_pkg::vrd_word_t word_in,
    output logic               done,
    output vrd_pkg::vrd_out_t  rsp
);

    localparam int VW = vrd_pkg::VEC_W;
    localparam int TW = vrd_pkg::TRIG_W;
    localparam int PW = vrd_pkg::PROD_W;
    localparam int SW = vrd_pkg::SUM_W;

    logic [vrd_pkg::MATH_STAGES-1:0] valid_reg;

    logic signed [TW-1:0] sin_reg;
    logic signed [TW-1:0] cos_reg;
    logic signed [VW-1:0] x_reg;
    logic signed [VW-1:0] y_reg;

    logic signed [PW-1:0] xc_reg;
    logic signed [PW-1:0] ys_reg;
    logic signed [PW-1:0] xs_reg;
    logic signed [PW-1:0] yc_reg;

    logic signed [SW-1:0] sum_x_reg;
    logic signed [SW-1:0] sum_y_reg;

    vrd_pkg::vrd_sat_t  sat_x;
    vrd_pkg::vrd_sat_t  sat_y;
    vrd_pkg::vrd_out_t  rsp_reg;
    vrd_pkg::vrd_out_t  rsp_next;
    logic [vrd_pkg::DEG_W-1:0] deg;

    // The last modulo cell leaves an angle below 360.
    assign deg = word_in.angle[vrd_pkg::DEG_W-1:0];

    always_comb
    begin
        sat_x              = vrd_pkg::round_sat(sum_x_reg);
        sat_y              = vrd_pkg::round_sat(sum_y_reg);
        rsp_next.rot_x     = sat_x.value;
        rsp_next.rot_y     = sat_y.value;
        rsp_next.saturated = sat_x.clip | sat_y.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[vrd_pkg::MATH_STAGES-2:0], word_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        sin_reg   <= vrd_pkg::sin_deg(deg);
        cos_reg   <= vrd_pkg::cos_deg(deg);
        x_reg     <= word_in.vec_x;
        y_reg     <= word_in.vec_y;

        xc_reg    <= PW'(x_reg * cos_reg);
        ys_reg    <= PW'(y_reg * sin_reg);
        xs_reg    <= PW'(x_reg * sin_reg);
        yc_reg    <= PW'(y_reg * cos_reg);

        sum_x_reg <= SW'(xc_reg) - SW'(ys_reg);
        sum_y_reg <= SW'(xs_reg) + SW'(yc_reg);

        rsp_reg   <= rsp_next;
    end

    assign done = valid_reg[vrd_pkg::MATH_STAGES-1];
    assign rsp  = rsp_reg;

endmodule

// ===== rtl/core/vrd_checker.sv =====
`include "vector_rotate_degrees_macros.svh"

module vrd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input vrd_pkg::vrd_in_t  req,
    input logic              done,
    input vrd_pkg::vrd_out_t rsp
);

    localparam int LAT = vrd_pkg::LATENCY;

    logic              took;
    logic              zero_in;
    logic              at_rail;
    vrd_pkg::vrd_out_t in_word;

    assign took    = start && !busy;
    assign zero_in = took && (req.angle_deg == '0);
    assign at_rail = (rsp.rot_x == vrd_pkg::SAT_MAX) || (rsp.rot_x == vrd_pkg::SAT_MIN)
                     || (rsp.rot_y == vrd_pkg::SAT_MAX) || (rsp.rot_y == vrd_pkg::SAT_MIN);

    // The input vector as a result word, which is what a zero angle must return.
    assign in_word.rot_x     = req.vec_x;
    assign in_word.rot_y     = req.vec_y;
    assign in_word.saturated = 1'b0;

    `VRD_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
    `VRD_ASSERT_DELAY(a_done_follows_start, took, LAT, done, "word lost")
    `VRD_ASSERT_IMP(a_done_has_start, done, $past(took, LAT), "extra result")
    `VRD_ASSERT_IMP(a_sat_at_rail, done && rsp.saturated, at_rail, "flag set with no clipped output")
    // A zero angle must return the input vector unchanged.
    `VRD_ASSERT_IMP(a_zero_angle, $past(zero_in, LAT), rsp == $past(in_word, LAT), "zero angle moved it")

endmodule

bind vector_rotate_degrees vrd_checker u_vrd_checker (.*);

// ===== tb/vector_rotate_degrees_tb.sv =====
`timescale 1ns / 100ps

module vector_rotate_degrees_tb;

    import vrd_pkg::*;

    localparam int                IDLE_LIMIT = 2000;
    localparam longint unsigned   PI_Q60     = 64'h3243F6A8885A308D;
    localparam longint unsigned   ONE_Q60    = 64'h1000000000000000;

    typedef struct {
        vrd_in_t word;
        int      gap;
        bit      drain;
    } pending_t;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    vrd_in_t  req   = '0;
    logic     busy;
    logic     done;
    vrd_out_t rsp;

    pending_t vector_q[$];
    vrd_out_t rotated_q[$];
    longint   sine_q16[0:90];
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       hold_cnt = 0;
    logic     accepted_q;

    vector_rotate_degrees u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Q60 fixed-point multiply; the product is known to stay below 16.
    function automatic longint unsigned mul_q60(input longint unsigned a,
                                                input longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Taylor series for sin(k degrees) in Q60, rounded to Q1.16.
    function automatic longint sine_entry(input int k);
        longint unsigned deg;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        bit              sub;
        int              n;
        deg  = (PI_Q60 + 64'd90) / 64'd180;
        x    = deg * longint'(k);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        sub  = 1'b1;
        for (n = 1; n < 61 && term != 0; n += 2)
        begin
            term = mul_q60(term, x2) / longint'((n + 1) * (n + 2));
            sum  = sub ? sum - term : sum + term;
            sub  = !sub;
        end
        if (sum > ONE_Q60)
        begin
            sum = ONE_Q60;
        end
        sum = (sum + (64'd1 << (59 - TRIG_FRAC))) >> (60 - TRIG_FRAC);
        return longint'(sum);
    endfunction

    function automatic longint sine_of_deg(input int a);
        if (a <= 90)
        begin
            return sine_q16[a];
        end
        else if (a <= 180)
        begin
            return sine_q16[180 - a];
        end
        else if (a <= 270)
        begin
            return -sine_q16[a - 180];
        end
        return -sine_q16[360 - a];
    endfunction

    // Round half up from Q32 to Q16 and clip to the 32-bit range.
    function automatic longint round_clip(input longint sum, inout bit clip);
        longint r;
        r = (sum + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        if (r > 64'sd2147483647)
        begin
            clip = 1'b1;
            return 64'sd2147483647;
        end
        if (r < -64'sd2147483648)
        begin
            clip = 1'b1;
            return -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic vrd_out_t rotate_vector(input vrd_in_t w);
        longint   x;
        longint   y;
        longint   s;
        longint   c;
        longint   rx;
        longint   ry;
        int       a;
        bit       clip;
        vrd_out_t res;
        x    = longint'($signed(w.vec_x));
        y    = longint'($signed(w.vec_y));
        a    = int'($signed(w.angle_deg)) % 360;
        clip = 1'b0;
        if (a < 0)
        begin
            a += 360;
        end
        s  = sine_of_deg(a);
        c  = sine_of_deg((a + 90) % 360);
        rx = round_clip(x * c - y * s, clip);
        ry = round_clip(x * s + y * c, clip);
        res.rot_x     = rx[VEC_W-1:0];
        res.rot_y     = ry[VEC_W-1:0];
        res.saturated = clip;
        return res;
    endfunction

    task automatic add_vector(input logic [31:0] x, input logic [31:0] y,
                              input logic [15:0] ang, input bit drain, input int gap);
        pending_t p;
        p.word.vec_x     = x;
        p.word.vec_y     = y;
        p.word.angle_deg = ang;
        p.drain          = drain;
        p.gap            = gap;
        vector_q.push_back(p);
    endtask

    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return SAT_MAX;
                    1: return SAT_MIN;
                    2: return 32'd0;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            2: return SAT_MAX - $urandom_range(0, 65535);
            3: return SAT_MIN + $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] random_angle();
        case ($urandom_range(0, 4))
            0: return 16'(($signed($urandom_range(0, 728)) - 364) * 90);
            1: return 16'($signed($urandom_range(0, 1440)) - 720);
            2: return $urandom_range(0, 1) ? 16'(16'h8000 + $urandom_range(0, 400))
                                            : 16'(16'h7FFF - $urandom_range(0, 400));
            default: return 16'($urandom);
        endcase
    endfunction

    // Driver: a word stays on req until it is taken, then the next one follows
    // after its drawn gap. A drain word waits until every result has come back.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else if (!(start && !accepted_q))
        begin
            if (hold_cnt > 0)
            begin
                hold_cnt = hold_cnt - 1;
                start   <= 1'b0;
            end
            else if (vector_q.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (vector_q[0].drain && rotated_q.size() != 0)
            begin
                start <= 1'b0;
            end
            else
            begin
                req      <= vector_q[0].word;
                hold_cnt  = vector_q[0].gap;
                start    <= 1'b1;
                void'(vector_q.pop_front());
            end
        end
    end

    // Monitor: predict on every accepted word and check every result.
    always @(posedge clk or negedge rst_n)
    begin
        vrd_out_t want;
        if (!rst_n)
        begin
            accepted_q <= 1'b0;
        end
        else
        begin
            accepted_q <= start && !busy;
            if (start && !busy)
            begin
                rotated_q.push_back(rotate_vector(req));
            end
            if (done)
            begin
                if (rotated_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result expected none actual %0d %0d %0b",
                             $time, rsp.rot_x, rsp.rot_y, rsp.saturated);
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (rsp.rot_x !== want.rot_x)
                    begin
                        mismatches++;
                        $display("%0t: rot_x mismatch expected %0d actual %0d",
                                 $time, want.rot_x, rsp.rot_x);
                    end
                    if (rsp.rot_y !== want.rot_y)
                    begin
                        mismatches++;
                        $display("%0t: rot_y mismatch expected %0d actual %0d",
                                 $time, want.rot_y, rsp.rot_y);
                    end
                    if (rsp.saturated !== want.saturated)
                    begin
                        mismatches++;
                        $display("%0t: saturated mismatch expected %0b actual %0b",
                                 $time, want.saturated, rsp.saturated);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int  i;
        bit  burst;
        for (i = 0; i <= 90; i++)
        begin
            sine_q16[i] = sine_entry(i);
        end

        // Directed words: quadrant angles, wrap-around and negative angles,
        // the angle extremes, rounding ties and clipping in both directions.
        add_vector(32'h0001_0000, 32'd0,        16'd0,     1'b0, 0);
        add_vector(32'h0001_0000, 32'h0002_0000, 16'd90,   1'b0, 0);
        add_vector(32'h0001_0000, 32'h0002_0000, 16'd180,  1'b0, 1);
        add_vector(32'h0001_0000, 32'h0002_0000, 16'd270,  1'b0, 0);
        add_vector(32'h0001_0000, 32'h0002_0000, 16'd359,  1'b0, 2);
        add_vector(32'h0001_0000, 32'h0002_0000, 16'd360,  1'b0, 0);
        add_vector(32'h0003_0000, 32'hFFFF_0000, -16'sd90, 1'b0, 0);
        add_vector(32'h0003_0000, 32'hFFFF_0000, -16'sd1,  1'b0, 3);
        add_vector(32'h1234_5678, 32'h8765_4321, 16'h8000, 1'b0, 0);
        add_vector(32'h1234_5678, 32'h8765_4321, 16'h7FFF, 1'b0, 0);
        add_vector(32'd1,         32'd0,        16'd30,    1'b0, 0);
        add_vector(32'hFFFF_FFFF, 32'd0,        16'd30,    1'b0, 0);
        add_vector(32'd0,         32'd1,        16'd60,    1'b0, 0);
        add_vector(SAT_MAX,       SAT_MAX,      16'd45,    1'b0, 0);
        add_vector(SAT_MIN,       SAT_MIN,      16'd45,    1'b0, 0);
        add_vector(SAT_MIN,       32'd0,        16'd180,   1'b0, 0);
        add_vector(32'd0,         SAT_MIN,      16'd180,   1'b0, 0);
        add_vector(SAT_MIN,       SAT_MIN,      16'd0,     1'b0, 0);
        add_vector(SAT_MAX,       SAT_MIN,      16'd315,   1'b0, 4);
        add_vector(SAT_MIN,       SAT_MAX,      16'd135,   1'b1, 0);
        add_vector(32'd0,         32'd0,        16'd17,    1'b0, 0);
        add_vector(SAT_MAX,       32'd0,        16'd90,    1'b0, 5);
        add_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd225,  1'b0, 0);

        burst = 1'b0;
        for (i = 0; i < 950; i++)
        begin
            if (i % 40 == 0)
            begin
                burst = ($urandom_range(0, 3) == 0);
            end
            add_vector(random_component(), random_component(), random_angle(),
                       (i % 150 == 75) || ($urandom_range(0, 99) == 0),
                       burst ? 0 : $urandom_range(0, 5));
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (vector_q.size() != 0 || start)
        begin
            @(posedge clk);
        end
        while (rotated_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);

        if (mismatches == 0 && rotated_q.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
